// ----- rtl/lca_pkg.sv -----
// package: shared types and constants for lba/chs translation
`timescale 1ns / 1ps
package lca_pkg;
    localparam int LbaW  = 32;
    localparam int CylW  = 16;
    localparam int HeadW = 8;
    localparam int SecW  = 8;
    localparam int HpcW  = 9;
    localparam int SptW  = 8;
    localparam logic [CylW-1:0] CylMax = 16'hFFFF;

    typedef enum logic [0:0] {
        REG_HEADS = 1'b0,
        REG_SPT   = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        FUNC_CHS2LBA = 1'b0,
        FUNC_LBA2CHS = 1'b1
    } t_func;

    typedef struct packed {
        logic             func;
        logic [LbaW-1:0]  lba_in;
        logic [CylW-1:0]  cylinder_in;
        logic [HeadW-1:0] head_in;
        logic [SecW-1:0]  sector_in;
    } t_in_item;

    typedef struct packed {
        logic [LbaW-1:0]  lba_out;
        logic [CylW-1:0]  cylinder_out;
        logic [HeadW-1:0] head_out;
        logic [SecW-1:0]  sector_out;
        logic             range_error;
    } t_out_item;
endpackage

// ----- rtl/lca_if.sv -----
// interfaces: valid/ready channels for input and result items
`timescale 1ns / 1ps
interface lca_in_if;
    import lca_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lca_out_if;
    import lca_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lba_chs_address_translation.sv -----
// top level: pipelined lba <-> chs address translation
// throughput: one item per cycle when not stalled; 32 stages divide lba by spt,
// then 32 more stages divide the track by heads
// stall: the whole pipeline holds while a result waits
// reset: geometry returns to 255 heads, 63 sectors; pipeline valids clear
`timescale 1ns / 1ps
module lba_chs_address_translation (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [lca_pkg::HpcW-1:0]  i_cfg_data,
    lca_in_if.sink                    in_ch,
    lca_out_if.source                 out_ch
);
    import lca_pkg::*;
    localparam int Nd = 32;
    localparam int Ns = 2 * Nd + 2;

    logic [HpcW-1:0] r_hpc;
    logic [SptW-1:0] r_spt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpc <= 9'd255;
            r_spt <= 8'd63;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_HEADS: r_hpc <= i_cfg_data;
                REG_SPT:   r_spt <= i_cfg_data[SptW-1:0];
                default: ;
            endcase
        end
    end

    logic w_geo_ok;
    assign w_geo_ok = (r_hpc != '0) && (r_hpc <= 9'd256) && (r_spt != '0);

    // pipeline valid and enable
    logic [Ns-1:0] r_vld;
    logic          w_en;
    assign w_en        = !r_vld[Ns-1] || out_ch.ready;
    assign in_ch.ready = w_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[Ns-2:0], in_ch.valid};
    end

    // stage 0: capture and chs->lba partial product
    t_in_item    r_it [2*Nd+1];
    logic [24:0] r_ch0;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it[0] <= in_ch.data;
            r_ch0   <= 25'(in_ch.data.cylinder_in * r_hpc) + 25'(in_ch.data.head_in);
            for (int k = 1; k < 2 * Nd + 1; k++) r_it[k] <= r_it[k-1];
        end
    end

    // divider chain: lba / spt
    logic [LbaW-1:0] w_q [Nd+1];
    logic [16:0]     w_r [Nd+1];
    assign w_q[0] = '0;
    assign w_r[0] = '0;
    genvar g;
    generate
        for (g = 0; g < Nd; g++) begin : g_div
            lca_div_stage u_st (
                .i_clk (i_clk), .i_en (w_en),
                .i_num (r_it[g].lba_in), .i_quo (w_q[g]), .i_rem (w_r[g]),
                .i_den ({9'd0, r_spt}), .i_bit (5'(Nd - 1 - g)),
                .o_quo (w_q[g+1]), .o_rem (w_r[g+1])
            );
        end
    endgenerate

    // chs product carried alongside, second multiply after stage 0
    logic [LbaW-1:0] r_chl [2*Nd];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_chl[0] <= 32'(r_ch0 * r_spt);
            for (int k = 1; k < 2 * Nd; k++) r_chl[k] <= r_chl[k-1];
        end
    end

    // track and sector carried through the second divider
    logic [LbaW-1:0] r_trk [Nd-1];
    logic [SecW-1:0] r_sec [Nd];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_trk[0] <= w_q[Nd];
            for (int k = 1; k < Nd - 1; k++) r_trk[k] <= r_trk[k-1];
            r_sec[0] <= 8'(w_r[Nd][7:0] + 8'd1);
            for (int k = 1; k < Nd; k++) r_sec[k] <= r_sec[k-1];
        end
    end

    logic [LbaW-1:0] w_tn [Nd];
    assign w_tn[0] = w_q[Nd];
    generate
        for (g = 1; g < Nd; g++) begin : g_trk
            assign w_tn[g] = r_trk[g-1];
        end
    endgenerate

    // divider chain: track / heads gives cylinder and head
    logic [LbaW-1:0] w_cq [Nd+1];
    logic [16:0]     w_hr [Nd+1];
    assign w_cq[0] = '0;
    assign w_hr[0] = '0;
    generate
        for (g = 0; g < Nd; g++) begin : g_cyl
            lca_div_stage u_st (
                .i_clk (i_clk), .i_en (w_en),
                .i_num (w_tn[g]), .i_quo (w_cq[g]), .i_rem (w_hr[g]),
                .i_den ({8'd0, r_hpc}), .i_bit (5'(Nd - 1 - g)),
                .o_quo (w_cq[g+1]), .o_rem (w_hr[g+1])
            );
        end
    endgenerate

    // final
    t_out_item r_out;
    t_out_item n_out;
    t_in_item  w_f;
    assign w_f = r_it[2*Nd];
    always_comb begin
        n_out = '0;
        if (!w_geo_ok) begin
            n_out.range_error = 1'b1;
        end else if (t_func'(w_f.func) == FUNC_CHS2LBA) begin
            n_out.lba_out = 32'(r_chl[2*Nd-1] + {24'd0, w_f.sector_in} - 32'd1);
            n_out.range_error = ({1'b0, w_f.head_in} >= r_hpc) ||
                (w_f.sector_in == '0) || (w_f.sector_in > r_spt);
        end else begin
            n_out.sector_out = r_sec[Nd-1];
            n_out.head_out   = w_hr[Nd][HeadW-1:0];
            if (w_cq[Nd] > {16'd0, CylMax}) begin
                n_out.cylinder_out = CylMax;
                n_out.range_error  = 1'b1;
            end else begin
                n_out.cylinder_out = w_cq[Nd][CylW-1:0];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= n_out;
    end

    assign out_ch.valid = r_vld[Ns-1];
    assign out_ch.data  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    a_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.data.range_error && out_ch.data.sector_out != 0
        |-> out_ch.data.sector_out <= r_spt)
        else $error("sector beyond geometry");
endmodule

// ----- rtl/lca_div_stage.sv -----
// module: one restoring division step stage that carries the partial quotient through
`timescale 1ns / 1ps
module lca_div_stage (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [lca_pkg::LbaW-1:0] i_num,
    input  logic [lca_pkg::LbaW-1:0] i_quo,
    input  logic [16:0]             i_rem,
    input  logic [16:0]             i_den,
    input  logic [4:0]              i_bit,
    output logic [lca_pkg::LbaW-1:0] o_quo,
    output logic [16:0]             o_rem
);
    import lca_pkg::*;
    logic [17:0]     n_trial;
    logic [16:0]     n_rem;
    logic [LbaW-1:0] n_quo;
    logic [LbaW-1:0] r_quo;
    logic [16:0]     r_rem;
    logic [4:0]      w_idx;
    always_comb begin
        w_idx   = i_bit;
        n_trial = {i_rem, i_num[w_idx]};
        n_quo   = i_quo;
        if (n_trial >= {1'b0, i_den}) begin
            n_rem        = 17'(n_trial - {1'b0, i_den});
            n_quo[w_idx] = 1'b1;
        end else begin
            n_rem = n_trial[16:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end
    assign o_quo = r_quo;
    assign o_rem = r_rem;
endmodule
